// ===== rtl/vector_heading_and_velocity_macros.svh =====
// assertion macros for the heading and velocity block
`ifndef VECTOR_HEADING_AND_VELOCITY_MACROS_SVH
`define VECTOR_HEADING_AND_VELOCITY_MACROS_SVH

`ifndef NO_ASSERTIONS

// implication checked on every edge outside reset
`define VHV_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vhv: check failed");

// state in the cycle after reset
`define VHV_ASSERT_RST(name, cons) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("vhv: reset check failed");

`else

`define VHV_ASSERT_IMP(name, ante, cons)
`define VHV_ASSERT_RST(name, cons)

`endif

`endif

// ===== rtl/vhv_pkg.sv =====
// shared types, tables and lookup functions for the heading and velocity block
package vhv_pkg;

  localparam int MAG_W      = 17;
  localparam int Q_W        = 9;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (Q_W - 1) / DIV_STEPS;
  localparam int ATAN_N     = 32;
  localparam int QUARTER_N  = 65;

  localparam logic [7:0] ZERO_HEADING = 8'd192;
  localparam logic [7:0] OCT_OFFSET   = 8'd80;
  localparam logic [7:0] QUARTER_TURN = 8'd64;
  localparam logic [7:0] HALF_TURN    = 8'd128;

  // per-item control carried down the pipe
  typedef struct packed {
    logic        kind;
    logic [7:0]  given;
    logic [14:0] speed;
    logic        neg_x;
    logic        neg_y;
    logic        steep;
    logic        zero;
  } meta_t;

  // divider state between stages
  typedef struct packed {
    meta_t             meta;
    logic [MAG_W-1:0]  den;
    logic [MAG_W-1:0]  rem;
    logic [Q_W-1:0]    quo;
  } div_t;

  // resolved heading with its speed
  typedef struct packed {
    logic [7:0]  heading;
    logic [14:0] speed;
  } ang_t;

  // smallest quotient at which the arctangent entry reaches k+1
  localparam logic [Q_W-1:0] ATAN_STEP [ATAN_N] = '{
    9'd7,   9'd13,  9'd19,  9'd26,  9'd32,  9'd38,  9'd45,  9'd51,
    9'd58,  9'd65,  9'd71,  9'd78,  9'd85,  9'd92,  9'd99,  9'd107,
    9'd114, 9'd122, 9'd129, 9'd137, 9'd146, 9'd154, 9'd163, 9'd172,
    9'd181, 9'd190, 9'd200, 9'd211, 9'd221, 9'd233, 9'd244, 9'd256
  };

  // first quadrant of the sine table, scaled by 256
  localparam logic [8:0] QUARTER_SINE [QUARTER_N] = '{
    9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,  9'd49,
    9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,  9'd97,  9'd103,
    9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136, 9'd142, 9'd147, 9'd152,
    9'd157, 9'd162, 9'd167, 9'd171, 9'd176, 9'd181, 9'd185, 9'd189, 9'd193,
    9'd197, 9'd201, 9'd205, 9'd209, 9'd212, 9'd216, 9'd219, 9'd222, 9'd225,
    9'd228, 9'd231, 9'd234, 9'd236, 9'd238, 9'd241, 9'd243, 9'd244, 9'd246,
    9'd248, 9'd249, 9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255,
    9'd255, 9'd256
  };

  // arctangent table as a count of thresholds passed
  function automatic logic [5:0] atan_lookup(logic [Q_W-1:0] q);
    logic [5:0] n;
    n = '0;
    for (int k = 0; k < ATAN_N; k++) begin
      if (q >= ATAN_STEP[k]) n = n + 6'd1;
    end
    return n;
  endfunction

  // signed sine entry, range -256 to 256
  function automatic logic signed [9:0] sin_lookup(logic [7:0] h);
    logic [6:0] idx;
    logic [9:0] mag;
    idx = h[6] ? (7'd64 - {1'b0, h[5:0]}) : {1'b0, h[5:0]};
    mag = {1'b0, QUARTER_SINE[idx]};
    return h[7] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== rtl/vhv_front.sv =====
// input stage: magnitudes, octant flags and the leading quotient bit
module vhv_front
  import vhv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  input  logic [7:0]        given_heading,
  input  logic [14:0]       speed,
  output logic              out_valid,
  input  logic              out_ready,
  output div_t              out_data
);

  logic signed [MAG_W-1:0] sx;
  logic signed [MAG_W-1:0] sy;
  logic [MAG_W-1:0]        ax;
  logic [MAG_W-1:0]        ay;
  logic [MAG_W-1:0]        small_mag;
  logic [MAG_W-1:0]        large_mag;
  logic                    top_bit;
  div_t                    out_data_next;

  // absolute values, 17 bits so that the most negative delta fits
  assign sx = MAG_W'(delta_x);
  assign sy = MAG_W'(delta_y);
  assign ax = delta_x[15] ? MAG_W'(-sx) : MAG_W'(sx);
  assign ay = delta_y[15] ? MAG_W'(-sy) : MAG_W'(sy);

  // order the magnitudes and take the first quotient bit
  always_comb begin
    out_data_next.meta.kind  = kind;
    out_data_next.meta.given = given_heading;
    out_data_next.meta.speed = speed;
    out_data_next.meta.neg_x = delta_x[15];
    out_data_next.meta.neg_y = delta_y[15];
    out_data_next.meta.steep = (ax <= ay);
    out_data_next.meta.zero  = (ax == '0) && (ay == '0);
    small_mag = out_data_next.meta.steep ? ax : ay;
    large_mag = out_data_next.meta.steep ? ay : ax;
    top_bit   = (small_mag >= large_mag);
    out_data_next.den = large_mag;
    out_data_next.rem = top_bit ? (small_mag - large_mag) : small_mag;
    out_data_next.quo = {{(Q_W-1){1'b0}}, top_bit};
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= out_data_next;
    end
  end

endmodule

// ===== rtl/vhv_div_stage.sv =====
// one divider stage: restoring steps on the remainder, one quotient bit each
module vhv_div_stage
  import vhv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  div_t           out_data_next;
  logic [MAG_W:0] trial;
  logic           qbit;

  // shift, compare against the divisor, subtract when it fits
  always_comb begin
    out_data_next = in_data;
    trial = '0;
    qbit  = 1'b0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {out_data_next.rem, 1'b0};
      qbit  = (trial >= {1'b0, out_data_next.den});
      if (qbit) trial = trial - {1'b0, out_data_next.den};
      out_data_next.rem = trial[MAG_W-1:0];
      out_data_next.quo = {out_data_next.quo[Q_W-2:0], qbit};
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= out_data_next;
    end
  end

endmodule

// ===== rtl/vhv_angle.sv =====
// heading stage: arctangent lookup and octant fold
module vhv_angle
  import vhv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ang_t out_data
);

  logic [5:0] base;
  logic [7:0] h;
  ang_t       out_data_next;

  // fold the first-octant angle out to the full turn
  always_comb begin
    base = atan_lookup(in_data.quo);
    h = in_data.meta.steep ? (QUARTER_TURN - {2'b00, base}) : {2'b00, base};
    if (in_data.meta.neg_x) h = HALF_TURN - h;
    if (in_data.meta.neg_y) h = 8'd0 - h;
    if (in_data.meta.zero)  h = ZERO_HEADING;
    if (in_data.meta.kind)  h = in_data.meta.given;
    out_data_next.heading = h;
    out_data_next.speed   = in_data.meta.speed;
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= out_data_next;
    end
  end

endmodule

// ===== rtl/vhv_vel.sv =====
// velocity stages: sine and cosine lookup, then the speed multiply
module vhv_vel
  import vhv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ang_t               in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         heading,
  output logic [2:0]         octant,
  output logic signed [15:0] vel_x,
  output logic signed [15:0] vel_y
);

  logic               a_valid;
  logic               a_ready;
  logic [7:0]         a_heading;
  logic [2:0]         a_octant;
  logic signed [9:0]  a_cos;
  logic signed [9:0]  a_sin;
  logic [14:0]        a_speed;
  logic               b_ready;
  logic [7:0]         oct_sum;
  logic signed [25:0] mul_x;
  logic signed [25:0] mul_y;
  logic signed [23:0] prod_x;
  logic signed [23:0] prod_y;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign oct_sum = in_data.heading + OCT_OFFSET;

  // table stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_heading <= in_data.heading;
      a_octant  <= oct_sum[7:5];
      a_cos     <= sin_lookup(in_data.heading + QUARTER_TURN);
      a_sin     <= sin_lookup(in_data.heading);
      a_speed   <= in_data.speed;
    end
  end

  // signed products, floor division by 256 is the arithmetic shift
  assign mul_x = a_cos * $signed({1'b0, a_speed});
  assign mul_y = a_sin * $signed({1'b0, a_speed});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      heading <= a_heading;
      octant  <= a_octant;
      prod_x  <= mul_x[23:0];
      prod_y  <= mul_y[23:0];
    end
  end

  assign vel_x = prod_x[23:8];
  assign vel_y = prod_y[23:8];

endmodule

// ===== rtl/vector_heading_and_velocity.sv =====
// top level of the heading and velocity block
//
//   beat     direction  handshake              payload
//   input    in         in_valid / in_stall    kind, delta_x, delta_y, given_heading, speed
//   result   out        out_valid / out_stall  heading, octant, vel_x, vel_y
//
// one beat in and one beat out per cycle when nothing stalls
// register stages in order: front, divider chain, heading, tables, multiply
// reset clears the valid bits of every stage; payload registers are not reset
// each stage holds only while it is full and the stage after it cannot take;
// empty stages keep filling, so in_stall rises only when every stage is full
`include "vector_heading_and_velocity_macros.svh"

module vector_heading_and_velocity
  import vhv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  input  logic [7:0]         given_heading,
  input  logic [14:0]        speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         heading,
  output logic [2:0]         octant,
  output logic signed [15:0] vel_x,
  output logic signed [15:0] vel_y
);

  logic front_ready;
  div_t div_data  [DIV_STAGES+1];
  logic div_valid [DIV_STAGES+1];
  logic div_ready [DIV_STAGES+1];
  logic ang_valid;
  logic ang_ready;
  ang_t ang_data;
  logic vel_ready;
  div_t tail;
  logic tail_live;

  assign in_stall = !front_ready;

  // magnitudes and first quotient bit
  vhv_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (front_ready),
    .kind          (kind),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .given_heading (given_heading),
    .speed         (speed),
    .out_valid     (div_valid[0]),
    .out_ready     (div_ready[0]),
    .out_data      (div_data[0])
  );

  // divider chain
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    vhv_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[g]),
      .in_ready  (div_ready[g]),
      .in_data   (div_data[g]),
      .out_valid (div_valid[g+1]),
      .out_ready (div_ready[g+1]),
      .out_data  (div_data[g+1])
    );
  end

  assign div_ready[DIV_STAGES] = ang_ready;

  // heading resolution
  vhv_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid[DIV_STAGES]),
    .in_ready  (ang_ready),
    .in_data   (div_data[DIV_STAGES]),
    .out_valid (ang_valid),
    .out_ready (vel_ready),
    .out_data  (ang_data)
  );

  // velocity and output register
  vhv_vel u_vel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ang_valid),
    .in_ready  (vel_ready),
    .in_data   (ang_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .heading   (heading),
    .octant    (octant),
    .vel_x     (vel_x),
    .vel_y     (vel_y)
  );

  // last divider stage, a zero vector leaves its quotient meaningless
  assign tail      = div_data[DIV_STAGES];
  assign tail_live = div_valid[DIV_STAGES] && !div_data[DIV_STAGES].meta.zero;

  // checks
  `VHV_ASSERT_RST(a_reset_empty, !out_valid && !in_stall)
  `VHV_ASSERT_IMP(a_stall_from_output, in_stall, out_valid && out_stall)
  `VHV_ASSERT_IMP(a_rem_below_divisor, tail_live, tail.rem < tail.den)
  `VHV_ASSERT_IMP(a_quotient_bound, tail_live && tail.quo[Q_W-1], tail.quo[Q_W-2:0] == '0)
  `VHV_ASSERT_IMP(a_octant_match, out_valid, octant == 3'((heading + OCT_OFFSET) >> 5))

endmodule
